@@ rtl/rd4_pkg.sv @@
// shared constants and types for the radix-4 divide stage
`timescale 1ns / 1ps

package rd4_pkg;

  localparam int REM_W   = 61;  // running remainder width
  localparam int DIFF_W  = 62;  // difference width, top bit is the borrow
  localparam int DIV_W   = 53;  // divisor width
  localparam int IDX_W   = 7;   // one index slice
  localparam int SLICES  = 8;   // slices in the index word
  localparam int TABLE_W = IDX_W * SLICES;
  localparam int QUO_W   = 8;   // quotient bits per word
  localparam int CELLS   = 4;   // radix-4 digits per word

  // word carried from cell to cell along the chain
  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [DIV_W-1:0]   d1;
    logic [DIV_W:0]     d2;
    logic [DIV_W+1:0]   d3;
    logic [QUO_W-1:0]   bits;
    logic               ena;
    logic [TABLE_W-1:0] table_word;
  } cell_word_t;

endpackage

@@ rtl/radix4_divide_stage_8bit.sv @@
// radix-4 divide stage, eight quotient bits through a chain of four digit cells
// a word passes the entry register, the register of each digit cell and the result register; done rises with the result
// throughput: one word per clock, busy is always low; one cell per digit, one register each
// reset: rst clears the valid bits of the chain and done; payload registers are not reset
// the receiver cannot stall: each result is shown for one cycle with done high
`timescale 1ns / 1ps

module radix4_divide_stage_8bit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rd4_pkg::REM_W-1:0]   partial_remainder,
  input  logic [rd4_pkg::DIV_W-1:0]   divisor_value,
  input  logic                        index_enable,
  input  logic [rd4_pkg::TABLE_W-1:0] index_table,
  output logic                        done,
  output logic [rd4_pkg::QUO_W-1:0]   quotient_bits,
  output logic [rd4_pkg::DIV_W-1:0]   remainder_out,
  output logic [rd4_pkg::IDX_W-1:0]   lead_index,
  output logic                        lead_ready
);
  import rd4_pkg::*;

  logic       chain_valid [0:CELLS];
  cell_word_t chain_word  [0:CELLS];
  logic       entry_valid;
  cell_word_t entry_word;
  cell_word_t entry_next;
  logic [IDX_W-1:0] lead_index_next;
  logic             lead_ready_next;

  // the chain takes a word every cycle
  assign busy = 1'b0;

  // entry word with 2D and 3D formed up front
  always_comb begin
    entry_next.rem        = partial_remainder;
    entry_next.d1         = divisor_value;
    entry_next.d2         = {divisor_value, 1'b0};
    entry_next.d3         = {divisor_value, 1'b0} + {2'b00, divisor_value};
    entry_next.bits       = '0;
    entry_next.ena        = index_enable;
    entry_next.table_word = index_table;
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else begin
      entry_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    entry_word <= entry_next;
  end

  assign chain_valid[0] = entry_valid;
  assign chain_word[0]  = entry_word;

  // digit cells, shifts 6, 4, 2, 0
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    rd4_cell #(
      .SHIFT(2 * (CELLS - 1 - i))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[i]),
      .in_word  (chain_word[i]),
      .out_valid(chain_valid[i+1]),
      .out_word (chain_word[i+1])
    );
  end

  // leading-digit index from the finished word
  rd4_lead u_lead (
    .bits      (chain_word[CELLS].bits),
    .ena       (chain_word[CELLS].ena),
    .table_word(chain_word[CELLS].table_word),
    .lead_index(lead_index_next),
    .lead_ready(lead_ready_next)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[CELLS];
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    quotient_bits <= chain_word[CELLS].bits;
    remainder_out <= chain_word[CELLS].rem[DIV_W-1:0];
    lead_index    <= lead_index_next;
    lead_ready    <= lead_ready_next;
  end

endmodule

@@ rtl/rd4_cell.sv @@
// one radix-4 restoring digit cell with its pipeline register
`timescale 1ns / 1ps

module rd4_cell #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rd4_pkg::cell_word_t in_word,
  output logic                out_valid,
  output rd4_pkg::cell_word_t out_word
);
  import rd4_pkg::*;

  logic [DIFF_W-1:0] rem_ext;
  logic [DIFF_W-1:0] mult1;
  logic [DIFF_W-1:0] mult2;
  logic [DIFF_W-1:0] mult3;
  logic [DIFF_W-1:0] diff1;
  logic [DIFF_W-1:0] diff2;
  logic [DIFF_W-1:0] diff3;
  logic [1:0]        digit;
  logic [REM_W-1:0]  rem_next;
  cell_word_t        word_next;

  // shifted multiples and the three trial differences
  assign rem_ext = {1'b0, in_word.rem};
  assign mult1   = {{(DIFF_W-DIV_W){1'b0}}, in_word.d1} << SHIFT;
  assign mult2   = {{(DIFF_W-DIV_W-1){1'b0}}, in_word.d2} << SHIFT;
  assign mult3   = {{(DIFF_W-DIV_W-2){1'b0}}, in_word.d3} << SHIFT;
  assign diff1   = rem_ext - mult1;
  assign diff2   = rem_ext - mult2;
  assign diff3   = rem_ext - mult3;

  // keep the largest multiple that does not borrow
  always_comb begin
    if (!diff3[DIFF_W-1]) begin
      digit    = 2'd3;
      rem_next = diff3[REM_W-1:0];
    end else if (!diff2[DIFF_W-1]) begin
      digit    = 2'd2;
      rem_next = diff2[REM_W-1:0];
    end else if (!diff1[DIFF_W-1]) begin
      digit    = 2'd1;
      rem_next = diff1[REM_W-1:0];
    end else begin
      digit    = 2'd0;
      rem_next = in_word.rem;
    end
  end

  // append the digit and hand the word on
  always_comb begin
    word_next      = in_word;
    word_next.rem  = rem_next;
    word_next.bits = {in_word.bits[QUO_W-3:0], digit};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

@@ rtl/rd4_lead.sv @@
// leading-digit index slice selection
`timescale 1ns / 1ps

module rd4_lead (
  input  logic [rd4_pkg::QUO_W-1:0]   bits,
  input  logic                        ena,
  input  logic [rd4_pkg::TABLE_W-1:0] table_word,
  output logic [rd4_pkg::IDX_W-1:0]   lead_index,
  output logic                        lead_ready
);
  import rd4_pkg::*;

  logic [IDX_W-1:0] slice;

  // slice at the highest set quotient bit, slice zero when none is set
  always_comb begin
    slice = table_word[IDX_W-1:0];
    for (int k = 0; k < QUO_W; k++) begin
      if (bits[k]) begin
        slice = table_word[k*IDX_W +: IDX_W];
      end
    end
  end

  // gate by enable; ready also needs a set quotient bit
  assign lead_index = ena ? slice : '0;
  assign lead_ready = ena && (bits != '0);

endmodule
